/* rtl/core/tcw_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and the microcode rom of the text console writer
// no dependencies; imported by tcw_useq and text_console_writer

package tcw_pkg;

   // transaction widths on the stream ports
   localparam int REQ_W = 24;
   localparam int RSP_W = 32;

   // character and attribute constants
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] ATTR_DARK    = 8'h0f;
   localparam logic [7:0] ATTR_LIGHT   = 8'hf0;

   // request action codes
   typedef enum logic [2:0] {
      ACT_WRITE = 3'd0,
      ACT_BACK  = 3'd1,
      ACT_CLEAR = 3'd2,
      ACT_THEME = 3'd3,
      ACT_READ  = 3'd4
   } action_type;

   // microprogram addresses
   typedef enum logic [4:0] {
      U_IDLE, U_EMIT,
      U_WR0, U_WR1,
      U_SC0, U_SC1, U_SC2, U_SC3,
      U_BS0, U_BS1, U_BS2,
      U_CLR0, U_CLR1,
      U_TG0, U_TG1,
      U_RD0, U_RD1,
      U_INIT
   } upc_type;

   // cell address register operations
   typedef enum logic [1:0] {
      ADDR_HOLD, ADDR_POS, ADDR_ZERO, ADDR_INC
   } addr_op_type;

   // character write data select
   typedef enum logic [1:0] {
      CH_REQ, CH_ZERO, CH_SPACE, CH_COPY
   } char_sel_type;

   // attribute write data select
   typedef enum logic {
      AT_THEME, AT_COPY
   } attr_sel_type;

   // cursor register operations
   typedef enum logic [1:0] {
      CUR_HOLD, CUR_PUT, CUR_BACK, CUR_HOME
   } cur_op_type;

   // sequencer branch conditions
   typedef enum logic [2:0] {
      C_GOTO,       // always to target
      C_WAIT_REQ,   // hold until a request, then dispatch on its action
      C_SCROLL,     // target when a scroll is due, else exit
      C_LOOP_BODY,  // target until the last cell above the bottom row, then exit
      C_LOOP_ALL,   // target until the last cell, then exit
      C_EMIT        // load the response when the slot is free, then target
   } cond_type;

   // one control word
   typedef struct packed {
      addr_op_type  addr_op;
      logic         rd_shift;   // read one row below the cell address
      logic         char_we;
      char_sel_type char_sel;
      logic         attr_we;
      attr_sel_type attr_sel;
      logic         nl_gate;    // suppress writes for a newline
      cur_op_type   cur_op;
      logic         theme_flip;
      cond_type     cond;
      upc_type      target;
      upc_type      exit;
   } ctrl_word_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic       req_valid;
      logic [2:0] action;
      logic       need_scroll;
      logic       last_all;
      logic       last_body;
      logic       out_free;
   } seq_status_type;

   localparam ctrl_word_type UCW_NOP = '{
      addr_op:    ADDR_HOLD,
      rd_shift:   1'b0,
      char_we:    1'b0,
      char_sel:   CH_REQ,
      attr_we:    1'b0,
      attr_sel:   AT_THEME,
      nl_gate:    1'b0,
      cur_op:     CUR_HOLD,
      theme_flip: 1'b0,
      cond:       C_GOTO,
      target:     U_IDLE,
      exit:       U_IDLE
   };

   // microcode rom
   function automatic ctrl_word_type ucode_word(upc_type addr);
      ctrl_word_type w;
      w = UCW_NOP;
      unique case (addr)
         U_IDLE: begin
            w.cond = C_WAIT_REQ;
         end
         U_EMIT: begin
            w.cond   = C_EMIT;
            w.target = U_IDLE;
         end
         // write a character or a newline
         U_WR0: begin
            w.addr_op = ADDR_POS;
            w.target  = U_WR1;
         end
         U_WR1: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_REQ;
            w.attr_we  = 1'b1;
            w.attr_sel = AT_THEME;
            w.nl_gate  = 1'b1;
            w.cur_op   = CUR_PUT;
            w.cond     = C_SCROLL;
            w.target   = U_SC0;
            w.exit     = U_EMIT;
         end
         // scroll: copy each row up, then blank the bottom row characters
         U_SC0: begin
            w.addr_op = ADDR_ZERO;
            w.target  = U_SC1;
         end
         U_SC1: begin
            w.rd_shift = 1'b1;
            w.target   = U_SC2;
         end
         U_SC2: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_COPY;
            w.attr_we  = 1'b1;
            w.attr_sel = AT_COPY;
            w.addr_op  = ADDR_INC;
            w.cond     = C_LOOP_BODY;
            w.target   = U_SC1;
            w.exit     = U_SC3;
         end
         U_SC3: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_ZERO;
            w.addr_op  = ADDR_INC;
            w.cond     = C_LOOP_ALL;
            w.target   = U_SC3;
            w.exit     = U_EMIT;
         end
         // backspace
         U_BS0: begin
            w.cur_op = CUR_BACK;
            w.target = U_BS1;
         end
         U_BS1: begin
            w.addr_op = ADDR_POS;
            w.target  = U_BS2;
         end
         U_BS2: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_ZERO;
            w.attr_we  = 1'b1;
            w.attr_sel = AT_THEME;
            w.target   = U_EMIT;
         end
         // clear screen
         U_CLR0: begin
            w.addr_op = ADDR_ZERO;
            w.cur_op  = CUR_HOME;
            w.target  = U_CLR1;
         end
         U_CLR1: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_SPACE;
            w.attr_we  = 1'b1;
            w.attr_sel = AT_THEME;
            w.addr_op  = ADDR_INC;
            w.cond     = C_LOOP_ALL;
            w.target   = U_CLR1;
            w.exit     = U_EMIT;
         end
         // theme toggle and attribute rewrite
         U_TG0: begin
            w.theme_flip = 1'b1;
            w.addr_op    = ADDR_ZERO;
            w.target     = U_TG1;
         end
         U_TG1: begin
            w.attr_we  = 1'b1;
            w.attr_sel = AT_THEME;
            w.addr_op  = ADDR_INC;
            w.cond     = C_LOOP_ALL;
            w.target   = U_TG1;
            w.exit     = U_EMIT;
         end
         // cell read: address, then a wait step for the registered read
         U_RD0: begin
            w.addr_op = ADDR_POS;
            w.target  = U_RD1;
         end
         U_RD1: begin
            w.target = U_EMIT;
         end
         // clearing pass after reset
         U_INIT: begin
            w.char_we  = 1'b1;
            w.char_sel = CH_SPACE;
            w.attr_we  = 1'b1;
            w.attr_sel = AT_THEME;
            w.addr_op  = ADDR_INC;
            w.cond     = C_LOOP_ALL;
            w.target   = U_INIT;
            w.exit     = U_IDLE;
         end
         default: begin
            w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/tcw_cell_mem.sv */
`timescale 1ns / 1ps
// character and attribute cell store: one write port, one registered read port
// no dependencies

module tcw_cell_mem #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          ch_we,
   input  logic          at_we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    ch_wdata,
   input  logic [7:0]    at_wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    ch_rdata,
   output logic [7:0]    at_rdata
);

   logic [7:0] ch_mem [DEPTH];
   logic [7:0] at_mem [DEPTH];
   logic [7:0] ch_rdata_ff;
   logic [7:0] at_rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ch_we) begin
         ch_mem[waddr] <= ch_wdata;
      end
      if (at_we) begin
         at_mem[waddr] <= at_wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      ch_rdata_ff <= ch_mem[raddr];
      at_rdata_ff <= at_mem[raddr];
   end

   assign ch_rdata = ch_rdata_ff;
   assign at_rdata = at_rdata_ff;

endmodule

/* rtl/core/tcw_useq.sv */
`timescale 1ns / 1ps
// microcode sequencer: program counter, control rom and branch logic
// depends on tcw_pkg

module tcw_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  tcw_pkg::seq_status_type status,
   output tcw_pkg::ctrl_word_type  ucw,
   output logic                   req_ready,
   output logic                   rsp_load
);

   import tcw_pkg::*;

   upc_type pc_ff;
   upc_type pc_in;

   // control word of the current step
   assign ucw = ucode_word(pc_ff);

   // program counter; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= U_INIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // branch resolution
   always_comb begin
      pc_in     = pc_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (ucw.cond)
         C_GOTO: begin
            pc_in = ucw.target;
         end
         C_WAIT_REQ: begin
            req_ready = 1'b1;
            if (status.req_valid) begin
               case (status.action)
                  ACT_WRITE: pc_in = U_WR0;
                  ACT_BACK:  pc_in = U_BS0;
                  ACT_CLEAR: pc_in = U_CLR0;
                  ACT_THEME: pc_in = U_TG0;
                  ACT_READ:  pc_in = U_RD0;
                  default:   pc_in = U_EMIT;
               endcase
            end
         end
         C_SCROLL: begin
            pc_in = status.need_scroll ? ucw.target : ucw.exit;
         end
         C_LOOP_BODY: begin
            pc_in = status.last_body ? ucw.exit : ucw.target;
         end
         C_LOOP_ALL: begin
            pc_in = status.last_all ? ucw.exit : ucw.target;
         end
         C_EMIT: begin
            if (status.out_free) begin
               rsp_load = 1'b1;
               pc_in    = ucw.target;
            end
         end
         default: begin
            pc_in = U_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/text_console_writer.sv */
`timescale 1ns / 1ps
// text console writer top level: request decode, cursor and cell datapath
// depends on tcw_pkg, tcw_useq and tcw_cell_mem
//
// Usage: one request transaction on req_ (action, character, position) gives
// exactly one response transaction on rsp_ with the cursor after the action,
// the read cell (zero unless the action is a cell read) and the theme flag.
// Each action runs its microprogram steps, then the emit step, which loads the
// response once the response slot is free; an unknown action goes straight to
// the emit step. A write that scrolls adds the scroll steps.
// The next request is taken in the cycle after the response is loaded. The
// run time is set by the microprogram steps and the single write port of the
// cell store, which a scroll, a clear or a theme toggle walk one cell per cycle
// (the scroll copy takes a read step and a write step per cell). After reset a
// clearing pass over all cells fills the store with spaces and attribute 0x0f;
// req_tready stays low during it.
// A stalled receiver holds the response in its register; the block still
// accepts and processes the next request and waits at the point of loading.

module text_console_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   // request: action[2:0], char_code[10:3], use_position[11],
   // col_in[18:12], row_in[23:19]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [tcw_pkg::REQ_W-1:0] req_tdata,
   // response: cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
   // cell_attr[27:20], dark_now[28], zero[31:29]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [tcw_pkg::RSP_W-1:0] rsp_tdata
);

   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);

   localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [8:0]    COL_MAX9  = 9'(COLS - 1);
   localparam logic [7:0]    ROW_MAX8  = 8'(ROWS - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] BODY_LAST = AW'(CELLS - COLS - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);

   // request fields
   logic [2:0] req_action;
   logic [7:0] req_char;
   logic       req_use_pos;
   logic [6:0] req_col;
   logic [4:0] req_row;

   assign req_action  = req_tdata[2:0];
   assign req_char    = req_tdata[10:3];
   assign req_use_pos = req_tdata[11];
   assign req_col     = req_tdata[18:12];
   assign req_row     = req_tdata[23:19];

   // sequencer interface
   seq_status_type status;
   ctrl_word_type  ucw;
   logic           seq_ready;
   logic           rsp_load;
   logic           req_fire;

   // state
   logic [2:0]    action_ff;
   logic [7:0]    char_ff;
   logic [CW-1:0] pos_col_ff;
   logic [RW-1:0] pos_row_ff;
   logic [CW-1:0] cur_col_ff;
   logic [RW-1:0] cur_row_ff;
   logic [AW-1:0] addr_ff;
   logic          dark_ff;
   logic          rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // next values
   logic [CW-1:0] pos_col_in;
   logic [RW-1:0] pos_row_in;
   logic [CW-1:0] cur_col_in;
   logic [RW-1:0] cur_row_in;
   logic [AW-1:0] addr_in;

   // datapath combinational
   logic [CW-1:0] sat_col;
   logic [RW-1:0] sat_row;
   logic          is_newline;
   logic          wrap;
   logic          need_scroll;
   logic [CW-1:0] put_col;
   logic [RW-1:0] put_row;
   logic [CW-1:0] back_col;
   logic [RW-1:0] back_row;
   logic [AW-1:0] pos_addr;
   logic [AW-1:0] raddr;
   logic [7:0]    theme_attr;
   logic [7:0]    rd_char;
   logic [7:0]    rd_attr;
   logic [7:0]    ch_wdata;
   logic [7:0]    at_wdata;
   logic          wr_block;
   logic          ch_we;
   logic          at_we;
   logic [7:0]    out_char;
   logic [7:0]    out_attr;

   assign req_fire   = req_tvalid && seq_ready;
   assign req_tready = seq_ready;
   assign theme_attr = dark_ff ? ATTR_DARK : ATTR_LIGHT;

   // saturate the requested position to the screen
   assign sat_col = ({2'b00, req_col} > COL_MAX9) ? COL_LAST : CW'(req_col);
   assign sat_row = ({3'b000, req_row} > ROW_MAX8) ? ROW_LAST : RW'(req_row);

   // cursor after a put at the latched position
   assign is_newline  = (char_ff == CHAR_NEWLINE);
   assign wrap        = is_newline || (pos_col_ff == COL_LAST);
   assign need_scroll = wrap && (pos_row_ff == ROW_LAST);
   assign put_col     = wrap ? '0 : pos_col_ff + CW'(1);
   assign put_row     = (wrap && !need_scroll) ? pos_row_ff + RW'(1) : pos_row_ff;

   // cursor one cell back, saturating at the origin
   always_comb begin
      back_col = cur_col_ff;
      back_row = cur_row_ff;
      if (cur_col_ff != '0) begin
         back_col = cur_col_ff - CW'(1);
      end else if (cur_row_ff != '0) begin
         back_col = COL_LAST;
         back_row = cur_row_ff - RW'(1);
      end
   end

   // linear cell index of the latched position
   assign pos_addr = AW'(AW'(pos_row_ff) * ROW_STEP + AW'(pos_col_ff));

   // status to the sequencer
   always_comb begin
      status.req_valid   = req_tvalid;
      status.action      = req_action;
      status.need_scroll = need_scroll;
      status.last_all    = (addr_ff == ADDR_LAST);
      status.last_body   = (addr_ff == BODY_LAST);
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   tcw_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .ucw       (ucw),
      .req_ready (seq_ready),
      .rsp_load  (rsp_load)
   );

   // cell store write data and enables
   always_comb begin
      case (ucw.char_sel)
         CH_REQ:   ch_wdata = char_ff;
         CH_ZERO:  ch_wdata = CHAR_NUL;
         CH_SPACE: ch_wdata = CHAR_SPACE;
         CH_COPY:  ch_wdata = rd_char;
         default:  ch_wdata = CHAR_NUL;
      endcase
      case (ucw.attr_sel)
         AT_THEME: at_wdata = theme_attr;
         AT_COPY:  at_wdata = rd_attr;
         default:  at_wdata = theme_attr;
      endcase
   end

   assign wr_block = ucw.nl_gate && is_newline;
   assign ch_we    = ucw.char_we && !wr_block;
   assign at_we    = ucw.attr_we && !wr_block;
   assign raddr    = ucw.rd_shift ? addr_ff + ROW_STEP : addr_ff;

   tcw_cell_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_mem (
      .clock    (clock),
      .ch_we    (ch_we),
      .at_we    (at_we),
      .waddr    (addr_ff),
      .ch_wdata (ch_wdata),
      .at_wdata (at_wdata),
      .raddr    (raddr),
      .ch_rdata (rd_char),
      .at_rdata (rd_attr)
   );

   // next cursor, position and cell address
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      pos_col_in = pos_col_ff;
      pos_row_in = pos_row_ff;
      if (req_fire) begin
         if (req_use_pos || (req_action == ACT_READ)) begin
            pos_col_in = sat_col;
            pos_row_in = sat_row;
         end else begin
            pos_col_in = cur_col_ff;
            pos_row_in = cur_row_ff;
         end
      end
      case (ucw.cur_op)
         CUR_PUT: begin
            cur_col_in = put_col;
            cur_row_in = put_row;
         end
         CUR_BACK: begin
            cur_col_in = back_col;
            cur_row_in = back_row;
            pos_col_in = back_col;
            pos_row_in = back_row;
         end
         CUR_HOME: begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
         default: begin
         end
      endcase
      // the sweep address wraps to the first cell after the last one
      case (ucw.addr_op)
         ADDR_POS:  addr_in = pos_addr;
         ADDR_ZERO: addr_in = '0;
         ADDR_INC:  addr_in = (addr_ff == ADDR_LAST) ? '0 : addr_ff + AW'(1);
         default:   addr_in = addr_ff;
      endcase
   end

   // control state: cursor, sweep address, theme and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         addr_ff      <= '0;
         dark_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         addr_ff    <= addr_in;
         if (ucw.theme_flip) begin
            dark_ff <= !dark_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response fields; the read cell is shown only for a cell read
   assign out_char = (action_ff == ACT_READ) ? rd_char : CHAR_NUL;
   assign out_attr = (action_ff == ACT_READ) ? rd_attr : 8'h00;

   // request and response payload registers
   always_ff @(posedge clock) begin
      pos_col_ff <= pos_col_in;
      pos_row_ff <= pos_row_in;
      if (req_fire) begin
         action_ff <= req_action;
         char_ff   <= req_char;
      end
      if (rsp_load) begin
         rsp_data_ff <= {3'b000, dark_ff, out_attr, out_char,
                         5'(cur_row_ff), 7'(cur_col_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= COL_LAST) && (cur_row_ff <= ROW_LAST))
      else $error("cursor left the screen");

   // sweep address stays inside the store
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= ADDR_LAST)
      else $error("cell address beyond the store");

   // the theme changes only on a toggle step
   a_theme_flip: assert property (@(posedge clock) disable iff (reset)
      !$stable(dark_ff) |-> $past(ucw.theme_flip))
      else $error("theme changed without a toggle");

   // no store write in the cycle a request is taken
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !(ch_we || at_we))
      else $error("store written while taking a request");

endmodule
